/* hdl/apc_pkg.sv */
// Shared types, codes and constants of the attitude PID controller.
`timescale 1ns / 1ps
package apc_pkg;

  localparam int unsigned DivNumW  = 54;  // |diff| * 2^20 needs 53 bits, rounded to even
  localparam int unsigned DivDenW  = 20;
  localparam int unsigned DivSteps = DivNumW / 2;  // two quotient bits a cycle
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  localparam logic [DivDenW-1:0] ScaleDen = DivDenW'(100);

  // register indexes of the configuration port
  localparam logic [2:0] RegKpTilt     = 3'd0;
  localparam logic [2:0] RegKiTilt     = 3'd1;
  localparam logic [2:0] RegKdTilt     = 3'd2;
  localparam logic [2:0] RegKpHeading  = 3'd3;
  localparam logic [2:0] RegKiHeading  = 3'd4;
  localparam logic [2:0] RegKdHeading  = 3'd5;
  localparam logic [2:0] RegIntLimit   = 3'd6;
  localparam logic [2:0] RegThrFloor   = 3'd7;

  localparam logic [31:0] RstKpTilt    = 32'd3355443;
  localparam logic [31:0] RstKiTilt    = 32'd5033165;
  localparam logic [31:0] RstKdTilt    = 32'd838861;
  localparam logic [31:0] RstKpHeading = 32'd5033165;
  localparam logic [31:0] RstKiHeading = 32'd838861;
  localparam logic [31:0] RstKdHeading = 32'd2517;
  localparam logic [30:0] RstIntLimit  = 31'd1638400;
  localparam logic [11:0] RstThrFloor  = 12'd1060;

  localparam logic [1:0] AxisRoll  = 2'd0;
  localparam logic [1:0] AxisPitch = 2'd1;
  localparam logic [1:0] AxisYaw   = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_IMUL,
    ST_IUPD,
    ST_DSTART,
    ST_DWAIT,
    ST_GP,
    ST_GI,
    ST_GD,
    ST_GACC,
    ST_SSTART,
    ST_SWAIT,
    ST_DONE
  } apc_state_e;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_INT,
    MUL_P,
    MUL_I,
    MUL_D
  } mul_sel_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_THIRD  // subtract on roll and pitch, add on yaw
  } acc_op_e;

  typedef struct packed {
    logic       latch_in;
    mul_sel_e   mul_sel;
    acc_op_e    acc_op;
    logic       int_wr;
    logic       div_deriv;
    logic       div_sum;
    logic       deriv_wr;
    logic       drv_wr;
    logic       out_load;
    logic [1:0] axis;
  } apc_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } apc_status_t;

  function automatic logic [31:0] sat33(input logic [32:0] v);
    logic [31:0] r;
    if (v[32] != v[31]) begin
      r = v[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

/* hdl/apc_divider.sv */
// Radix-4 restoring divider for magnitudes, with signed 32-bit saturation of the quotient.
`timescale 1ns / 1ps
module apc_divider (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [apc_pkg::DivNumW-1:0] num_i,
  input  logic [apc_pkg::DivDenW-1:0] den_i,
  input  logic                        neg_i,
  output logic                        done_o,
  output logic [31:0]                 quot_o
);
  import apc_pkg::*;

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [DivCntW-1:0]  cnt_q, cnt_d;
  logic [DivDenW-1:0]  rem_q, rem_d;
  logic [DivNumW-1:0]  nq_q, nq_d;
  logic [DivDenW-1:0]  den_q;
  logic                neg_q;

  logic [DivDenW-1:0]  r_step;
  logic [DivNumW-1:0]  n_step;
  logic [DivDenW:0]    trial;

  always_comb begin
    r_step = rem_q;
    n_step = nq_q;
    trial  = '0;
    for (int k = 0; k < 2; k++) begin
      trial  = {r_step, n_step[DivNumW-1]};
      n_step = {n_step[DivNumW-2:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        trial     = trial - {1'b0, den_q};
        n_step[0] = 1'b1;
      end
      r_step = trial[DivDenW-1:0];
    end
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    nq_d   = nq_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      nq_d   = num_i;
    end else if (busy_q) begin
      rem_d = r_step;
      nq_d  = n_step;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DivCntW'(DivSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    nq_q  <= nq_d;
    if (start_i) begin
      den_q <= den_i;
      neg_q <= neg_i;
    end
  end

  always_comb begin
    if (neg_q) begin
      if (nq_q > DivNumW'(64'h8000_0000)) begin
        quot_o = 32'h8000_0000;
      end else begin
        quot_o = 32'(-nq_q[31:0]);
      end
    end else if (nq_q > DivNumW'(64'h7FFF_FFFF)) begin
      quot_o = 32'h7FFF_FFFF;
    end else begin
      quot_o = nq_q[31:0];
    end
  end

  assign done_o = done_q;

endmodule

/* hdl/apc_ctrl.sv */
// Sequencer of the controller: steps the shared multiplier and divider over the three axes.
`timescale 1ns / 1ps
module apc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  apc_pkg::apc_status_t status_i,
  output apc_pkg::apc_cmd_t    cmd_o
);
  import apc_pkg::*;

  apc_state_e state_q, state_d;
  logic [1:0] axis_q, axis_d;

  always_comb begin
    state_d = state_q;
    axis_d  = axis_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_IMUL;
          axis_d  = AxisRoll;
        end
      end
      ST_IMUL:   state_d = ST_IUPD;
      ST_IUPD:   state_d = (axis_q == AxisYaw) ? ST_DSTART : ST_GP;
      ST_DSTART: state_d = ST_DWAIT;
      ST_DWAIT: begin
        if (status_i.div_done) state_d = ST_GP;
      end
      ST_GP:     state_d = ST_GI;
      ST_GI:     state_d = ST_GD;
      ST_GD:     state_d = ST_GACC;
      ST_GACC:   state_d = ST_SSTART;
      ST_SSTART: state_d = ST_SWAIT;
      ST_SWAIT: begin
        if (status_i.div_done) begin
          if (axis_q == AxisYaw) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_IMUL;
            axis_d  = axis_q + 2'd1;
          end
        end
      end
      ST_DONE: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.mul_sel = MUL_NONE;
    cmd_o.acc_op  = ACC_HOLD;
    cmd_o.axis = axis_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o     = 1'b1;
        cmd_o.latch_in = in_valid_i;
      end
      ST_IMUL:   cmd_o.mul_sel = MUL_INT;
      ST_IUPD:   cmd_o.int_wr = 1'b1;
      ST_DSTART: cmd_o.div_deriv = 1'b1;
      ST_DWAIT:  cmd_o.deriv_wr = status_i.div_done;
      ST_GP:     cmd_o.mul_sel = MUL_P;
      ST_GI: begin
        cmd_o.mul_sel = MUL_I;
        cmd_o.acc_op  = ACC_LOAD;
      end
      ST_GD: begin
        cmd_o.mul_sel = MUL_D;
        cmd_o.acc_op  = ACC_ADD;
      end
      ST_GACC:   cmd_o.acc_op = ACC_THIRD;
      ST_SSTART: cmd_o.div_sum = 1'b1;
      ST_SWAIT:  cmd_o.drv_wr = status_i.div_done;
      ST_DONE:   cmd_o.out_load = status_i.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      axis_q  <= AxisRoll;
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
    end
  end

endmodule

/* hdl/apc_datapath.sv */
// Datapath: gains, integrators, shared multiplier, accumulator, divider and result registers.
`timescale 1ns / 1ps
module apc_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_idx_i,
  input  logic [31:0]          cfg_data_i,
  input  logic signed [31:0]   roll_target_i,
  input  logic signed [31:0]   pitch_target_i,
  input  logic signed [31:0]   yaw_rate_target_i,
  input  logic signed [31:0]   roll_measured_i,
  input  logic signed [31:0]   pitch_measured_i,
  input  logic [11:0]          throttle_pulse_i,
  input  logic signed [31:0]   gyro_roll_rate_i,
  input  logic signed [31:0]   gyro_pitch_rate_i,
  input  logic signed [31:0]   gyro_yaw_rate_i,
  input  logic [19:0]          tick_seconds_i,
  input  apc_pkg::apc_cmd_t    cmd_i,
  output apc_pkg::apc_status_t status_o,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic signed [31:0]   roll_drive_o,
  output logic signed [31:0]   pitch_drive_o,
  output logic signed [31:0]   yaw_drive_o
);
  import apc_pkg::*;

  // configuration
  logic [31:0] kp_tilt_q, ki_tilt_q, kd_tilt_q;
  logic [31:0] kp_head_q, ki_head_q, kd_head_q;
  logic [30:0] int_lim_q;
  logic [11:0] thr_floor_q;

  // per-item operands
  logic [31:0] err_q [3];
  logic [31:0] gyro_q [2];
  logic [19:0] dt_q;
  logic        low_q;

  // state carried between items
  logic [31:0] integ_q [3];
  logic [31:0] last_err_q;

  logic [31:0] deriv_q;
  logic [31:0] drv_q [3];
  logic [63:0] prod_q;
  logic signed [41:0] acc_q, acc_d;
  logic        out_valid_q;

  logic [31:0] gain_p, gain_i, gain_d, third;
  logic signed [32:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [64:0] prod_full;
  logic signed [39:0] gterm;

  logic [31:0] istep;
  logic signed [32:0] isum, ilim, inext;

  logic signed [32:0] ydiff;
  logic [32:0] ydiff_mag;
  logic [41:0] acc_mag;
  logic [DivNumW-1:0] div_num;
  logic [DivDenW-1:0] div_den;
  logic               div_neg, div_start, div_done;
  logic [31:0]        div_quot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_tilt_q   <= RstKpTilt;
      ki_tilt_q   <= RstKiTilt;
      kd_tilt_q   <= RstKdTilt;
      kp_head_q   <= RstKpHeading;
      ki_head_q   <= RstKiHeading;
      kd_head_q   <= RstKdHeading;
      int_lim_q   <= RstIntLimit;
      thr_floor_q <= RstThrFloor;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegKpTilt:    kp_tilt_q   <= cfg_data_i;
        RegKiTilt:    ki_tilt_q   <= cfg_data_i;
        RegKdTilt:    kd_tilt_q   <= cfg_data_i;
        RegKpHeading: kp_head_q   <= cfg_data_i;
        RegKiHeading: ki_head_q   <= cfg_data_i;
        RegKdHeading: kd_head_q   <= cfg_data_i;
        RegIntLimit:  int_lim_q   <= cfg_data_i[30:0];
        RegThrFloor:  thr_floor_q <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  // errors are formed as the item is taken
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      err_q[0]  <= sat33({roll_target_i[31], roll_target_i}
                         - {roll_measured_i[31], roll_measured_i});
      err_q[1]  <= sat33({pitch_target_i[31], pitch_target_i}
                         - {pitch_measured_i[31], pitch_measured_i});
      err_q[2]  <= sat33({yaw_rate_target_i[31], yaw_rate_target_i}
                         - {gyro_yaw_rate_i[31], gyro_yaw_rate_i});
      gyro_q[0] <= gyro_roll_rate_i;
      gyro_q[1] <= gyro_pitch_rate_i;
      dt_q      <= tick_seconds_i;
      low_q     <= (throttle_pulse_i < thr_floor_q);
    end
  end

  // operand selection for the shared multiplier
  always_comb begin
    if (cmd_i.axis == AxisYaw) begin
      gain_p = kp_head_q;
      gain_i = ki_head_q;
      gain_d = kd_head_q;
      third  = deriv_q;
    end else begin
      gain_p = kp_tilt_q;
      gain_i = ki_tilt_q;
      gain_d = kd_tilt_q;
      third  = gyro_q[cmd_i.axis[0]];
    end
    unique case (cmd_i.mul_sel)
      MUL_INT: begin
        mul_a = {13'b0, dt_q};
        mul_b = err_q[cmd_i.axis];
      end
      MUL_P: begin
        mul_a = {1'b0, gain_p};
        mul_b = err_q[cmd_i.axis];
      end
      MUL_I: begin
        mul_a = {1'b0, gain_i};
        mul_b = integ_q[cmd_i.axis];
      end
      MUL_D: begin
        mul_a = {1'b0, gain_d};
        mul_b = third;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_full = mul_a * mul_b;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_full[63:0];
  end

  // integrator: floor(err*dt / 2^20), clear on low throttle, clamp
  assign istep = prod_q[51:20];
  assign ilim  = {2'b00, int_lim_q};
  always_comb begin
    isum = {integ_q[cmd_i.axis][31], integ_q[cmd_i.axis]} + {istep[31], istep};
    if (low_q) begin
      inext = '0;
    end else begin
      inext = isum;
    end
    if (inext > ilim) begin
      inext = ilim;
    end else if (inext < -ilim) begin
      inext = -ilim;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q[0] <= '0;
      integ_q[1] <= '0;
      integ_q[2] <= '0;
      last_err_q <= '0;
    end else begin
      if (cmd_i.int_wr) integ_q[cmd_i.axis] <= inext[31:0];
      if (cmd_i.out_load) last_err_q <= err_q[2];
    end
  end

  // gain term is the product floor-shifted by 24
  assign gterm = prod_q[63:24];
  always_comb begin
    unique case (cmd_i.acc_op)
      ACC_LOAD: acc_d = 42'(gterm);
      ACC_ADD:  acc_d = acc_q + 42'(gterm);
      ACC_THIRD: begin
        if (cmd_i.axis == AxisYaw) acc_d = acc_q + 42'(gterm);
        else                       acc_d = acc_q - 42'(gterm);
      end
      default:  acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  // divider operands: yaw derivative or the sum over 100
  assign ydiff     = {err_q[2][31], err_q[2]} - {last_err_q[31], last_err_q};
  assign ydiff_mag = ydiff[32] ? 33'(-ydiff) : 33'(ydiff);
  assign acc_mag   = acc_q[41] ? 42'(-acc_q) : 42'(acc_q);

  always_comb begin
    if (cmd_i.div_deriv) begin
      div_num = {1'b0, ydiff_mag, 20'b0};
      div_den = dt_q;
      div_neg = ydiff[32];
    end else begin
      div_num = {12'b0, acc_mag};
      div_den = ScaleDen;
      div_neg = acc_q[41];
    end
  end

  assign div_start = cmd_i.div_deriv | cmd_i.div_sum;

  apc_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .neg_i   (div_neg),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.deriv_wr) deriv_q <= (dt_q == '0) ? '0 : div_quot;
    if (cmd_i.drv_wr) drv_q[cmd_i.axis] <= div_quot;
    if (cmd_i.out_load) begin
      roll_drive_o  <= drv_q[0];
      pitch_drive_o <= drv_q[1];
      yaw_drive_o   <= drv_q[2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o.div_done = div_done;
  assign status_o.out_free = ~out_valid_q | out_ready_i;

endmodule

/* hdl/attitude_pid_controller.sv */
// Top level of the attitude PID controller: sequencer plus datapath.
//
// Input channel: in_valid_i / in_ready_o carry one control tick per item
// (targets, measured angles, throttle, gyro rates, tick length).
// Output channel: out_valid_o / out_ready_i carry roll, pitch and yaw drives.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i at once.
// From acceptance to a valid result an item makes three integrator and
// gain passes through the shared 33x32 multiplier, and four passes through
// the radix-4 divider of 27 steps each (yaw derivative and the scaling of
// each drive). No new item is taken while one is in work; the next is taken
// once the result has been loaded into the output register.
// The result sits in an output register, so the next item is accepted while
// the last result waits; a further result waits for the register to empty.
// Reset loads the default gains, limit and throttle floor, and clears the
// integrators and the stored yaw error; no result is pending after reset.
`timescale 1ns / 1ps
module attitude_pid_controller (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] roll_target_i,
  input  logic signed [31:0] pitch_target_i,
  input  logic signed [31:0] yaw_rate_target_i,
  input  logic signed [31:0] roll_measured_i,
  input  logic signed [31:0] pitch_measured_i,
  input  logic [11:0]        throttle_pulse_i,
  input  logic signed [31:0] gyro_roll_rate_i,
  input  logic signed [31:0] gyro_pitch_rate_i,
  input  logic signed [31:0] gyro_yaw_rate_i,
  input  logic [19:0]        tick_seconds_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] roll_drive_o,
  output logic signed [31:0] pitch_drive_o,
  output logic signed [31:0] yaw_drive_o
);
  import apc_pkg::*;

  apc_cmd_t    cmd;
  apc_status_t status;

  apc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  apc_datapath u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .roll_target_i     (roll_target_i),
    .pitch_target_i    (pitch_target_i),
    .yaw_rate_target_i (yaw_rate_target_i),
    .roll_measured_i   (roll_measured_i),
    .pitch_measured_i  (pitch_measured_i),
    .throttle_pulse_i  (throttle_pulse_i),
    .gyro_roll_rate_i  (gyro_roll_rate_i),
    .gyro_pitch_rate_i (gyro_pitch_rate_i),
    .gyro_yaw_rate_i   (gyro_yaw_rate_i),
    .tick_seconds_i    (tick_seconds_i),
    .cmd_i             (cmd),
    .status_o          (status),
    .out_ready_i       (out_ready_i),
    .out_valid_o       (out_valid_o),
    .roll_drive_o      (roll_drive_o),
    .pitch_drive_o     (pitch_drive_o),
    .yaw_drive_o       (yaw_drive_o)
  );

endmodule

/* hdl/apc_checker.sv */
// Port-level checks of the attitude PID controller, bound to the top level.
`timescale 1ns / 1ps
module apc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] roll_drive_o
);

  // a pending result is held until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(roll_drive_o))
    else $error("pending result dropped or changed");

  // once an item is taken the block is busy with it
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("item accepted while previous one in work");

  // no result can appear right after an item is taken
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !$rose(out_valid_o))
    else $error("result appeared too early");

endmodule

bind attitude_pid_controller apc_checker u_apc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .roll_drive_o (roll_drive_o)
);
